[src/sjog_pkg.sv]
// shared types, constants and opcodes for the stepper jog step generator
// depends on nothing; every other file of the block imports it
package sjog_pkg;

	// jog update rate and the widths that follow from it
	localparam int TICKS_PER_SECOND = 1000;
	localparam int SPD_W = 16;
	localparam int POS_W = 32;
	localparam int CNT_W = 31;
	localparam int MS_W  = 32;

	// reciprocal for splitting a speed into whole and partial steps per tick
	localparam int REC_S   = SPD_W + $clog2(TICKS_PER_SECOND);
	localparam int REC_K_W = SPD_W + 1;
	localparam longint unsigned REC_K =
		((64'd1 << REC_S) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);

	// whole steps per tick, remainder per tick, accumulated quotient
	localparam int A_RAW = SPD_W + 1 - $clog2(TICKS_PER_SECOND + 1);
	localparam int A_W   = (A_RAW < 1) ? 1 : A_RAW;
	localparam int R_RAW = $clog2(TICKS_PER_SECOND);
	localparam int R_W   = (R_RAW < 1) ? 1 : R_RAW;
	localparam int Q_W   = SPD_W + MS_W + 1 - $clog2(TICKS_PER_SECOND + 1);
	localparam int TGT_W = ((Q_W > POS_W) ? Q_W : POS_W) + 2;

	// config register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SPEED  = 3'd0,
		CFG_RETRACT    = 3'd1,
		CFG_DIR_FLIP   = 3'd2,
		CFG_KEEP_POWER = 3'd3,
		CFG_EN_POL     = 3'd4
	} cfg_idx_e;

	// command opcodes
	typedef enum logic [3:0] {
		OP_TICK      = 4'd0,
		OP_SET_SPEED = 4'd1,
		OP_START_JOG = 4'd2,
		OP_STOP_JOG  = 4'd3,
		OP_LIMIT     = 4'd4,
		OP_CLR_LIMIT = 4'd5,
		OP_STEP      = 4'd6,
		OP_SET_POS   = 4'd7,
		OP_SET_DIR   = 4'd8
	} op_e;

	// command word
	typedef struct packed {
		logic [3:0]              opcode;
		logic signed [POS_W-1:0] value;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [CNT_W-1:0]        step_count;
		logic                    direction_pin;
		logic signed [POS_W-1:0] position;
		logic                    limit_active;
		logic                    jog_active;
		logic                    enable_pin;
		logic                    accepted;
	} res_t;

	// configuration registers
	typedef struct packed {
		logic [SPD_W-1:0] max_speed_steps;
		logic [SPD_W-1:0] retraction_steps;
		logic             direction_flipped;
		logic             keep_powered;
		logic             enable_polarity;
	} cfg_t;

	// keep_powered write also forces the driver enable
	typedef struct packed {
		logic we;
		logic val;
	} kp_wr_t;

	// decoded set-speed command
	typedef struct packed {
		logic           ok;
		logic           neg;
		logic [A_W-1:0] whole;
		logic [R_W-1:0] part;
	} spd_t;

endpackage

[src/stepper_jog_step_generator.sv]
// top level: command register, config registers and result register
// depends on sjog_pkg and sjog_core
// a command is held in the command register, then its result word is loaded into the
// result register, where it is kept for as long as res_stall holds it
// throughput: one command per cycle while res_stall is low; the whole update, including the jog
// target add and clamp, runs in one pass from command to result register
// reset: asynchronous, all motor state and flags clear, config takes defaults
module stepper_jog_step_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  sjog_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_stall,
	output sjog_pkg::res_t                res,
	input  logic                          cfg_we,
	input  logic [sjog_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sjog_pkg::SPD_W-1:0]    cfg_data
);
	import sjog_pkg::*;

	logic   vld_s1;
	cmd_t   cmd_s1;
	logic   adv;
	res_t   res_c;
	res_t   res_q;
	logic   res_vld_q;
	cfg_t   cfg_q;
	kp_wr_t kp_wr;

	// command moves on when the result register is free or being taken
	always_comb begin
		adv = vld_s1 && (!res_vld_q || !res_stall);
		cmd_stall = vld_s1 && !adv;
		kp_wr.we = cfg_we && (cfg_index == CFG_KEEP_POWER);
		kp_wr.val = cfg_data[0];
	end

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed_steps <= SPD_W'(1000);
			cfg_q.retraction_steps <= SPD_W'(100);
			cfg_q.direction_flipped <= 1'b0;
			cfg_q.keep_powered <= 1'b0;
			cfg_q.enable_polarity <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_SPEED:  cfg_q.max_speed_steps <= cfg_data;
				CFG_RETRACT:    cfg_q.retraction_steps <= cfg_data;
				CFG_DIR_FLIP:   cfg_q.direction_flipped <= cfg_data[0];
				CFG_KEEP_POWER: cfg_q.keep_powered <= cfg_data[0];
				CFG_EN_POL:     cfg_q.enable_polarity <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sjog_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd_s1),
		.cfg    (cfg_q),
		.kp_wr  (kp_wr),
		.res    (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (!res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_vld_q;
	assign res = res_q;

endmodule

[src/sjog_speed_div.sv]
// set-speed decode: magnitude check and split into steps per tick
// depends on sjog_pkg
module sjog_speed_div (
	input  logic signed [sjog_pkg::POS_W-1:0] value,
	input  logic [sjog_pkg::SPD_W-1:0]        max_speed,
	output sjog_pkg::spd_t                    spd
);
	import sjog_pkg::*;

	localparam logic [REC_K_W-1:0] K = REC_K_W'(REC_K);

	logic [POS_W-1:0]         mag;
	logic [SPD_W-1:0]         m;
	logic [SPD_W+REC_K_W-1:0] prod;
	logic [A_W-1:0]           whole;
	logic [SPD_W-1:0]         whole_t;

	// magnitude as unsigned, most negative value included
	always_comb begin
		mag = value[POS_W-1] ? POS_W'(-value) : POS_W'(value);
		m = mag[SPD_W-1:0];
	end

	// divide by ticks per second through the reciprocal, then remainder
	always_comb begin
		prod = (SPD_W+REC_K_W)'(m) * (SPD_W+REC_K_W)'(K);
		whole = A_W'(prod >> REC_S);
		whole_t = SPD_W'(SPD_W'(whole) * SPD_W'(TICKS_PER_SECOND));
		spd.ok = (mag <= POS_W'(max_speed));
		spd.neg = value[POS_W-1];
		spd.whole = whole;
		spd.part = R_W'(m - whole_t);
	end

endmodule

[src/sjog_core.sv]
// motor state and per-command update for the jog step generator
// depends on sjog_pkg and sjog_speed_div
module sjog_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  sjog_pkg::cmd_t   cmd,
	input  sjog_pkg::cfg_t   cfg,
	input  sjog_pkg::kp_wr_t kp_wr,
	output sjog_pkg::res_t   res
);
	import sjog_pkg::*;

	localparam logic signed [TGT_W-1:0] TGT_MAX = TGT_W'(64'sd2147483647);
	localparam logic signed [TGT_W-1:0] TGT_MIN = TGT_W'(-64'sd2147483648);

	// state: speed is kept as sign, whole and partial steps per tick
	logic [POS_W-1:0] pos_q, seg_q;
	logic [MS_W-1:0]  ms_q;
	logic             sneg_q;
	logic [A_W-1:0]   whole_q;
	logic [R_W-1:0]   part_q;
	logic [Q_W-1:0]   quo_q;
	logic [R_W-1:0]   rem_q;
	logic             chg_q, jog_q, lim_q, dir_q, en_q;

	logic [POS_W-1:0] pos_n, seg_n;
	logic [MS_W-1:0]  ms_n;
	logic             sneg_n;
	logic [A_W-1:0]   whole_n;
	logic [R_W-1:0]   part_n;
	logic [Q_W-1:0]   quo_n;
	logic [R_W-1:0]   rem_n;
	logic             chg_n, jog_n, lim_n, dir_n, en_n;

	spd_t spd;

	logic [R_W:0]              rsum;
	logic                      carry;
	logic [R_W-1:0]            rem_t;
	logic [Q_W-1:0]            quo_t;
	logic [POS_W-1:0]          seg_t;
	logic [MS_W-1:0]           ms_t;
	logic signed [TGT_W-1:0]   offs, tgt_w;
	logic [POS_W-1:0]          tgt;
	logic signed [POS_W:0]     diff;
	logic [POS_W:0]            dmag;
	logic [CNT_W-1:0]          tick_cnt;
	logic [SPD_W:0]            retr;
	logic [CNT_W-1:0]          steps;
	logic                      acc;

	sjog_speed_div u_div (
		.value     (cmd.value),
		.max_speed (cfg.max_speed_steps),
		.spd       (spd)
	);

	// jog target for a tick: restart segment, add one tick of travel, or hold once the tick count saturates
	always_comb begin
		rsum = {1'b0, rem_q} + (R_W+1)'(part_q);
		carry = (rsum >= (R_W+1)'(TICKS_PER_SECOND));
		if (chg_q) begin
			seg_t = pos_q;
			ms_t = '0;
			quo_t = '0;
			rem_t = '0;
		end else if (&ms_q) begin
			seg_t = seg_q;
			ms_t = ms_q;
			quo_t = quo_q;
			rem_t = rem_q;
		end else begin
			seg_t = seg_q;
			ms_t = ms_q + MS_W'(1);
			quo_t = quo_q + Q_W'(whole_q) + Q_W'(carry);
			rem_t = carry ? R_W'(rsum - (R_W+1)'(TICKS_PER_SECOND)) : R_W'(rsum);
		end
		offs = sneg_q ? -TGT_W'(quo_t) : TGT_W'(quo_t);
		tgt_w = {{(TGT_W-POS_W){seg_t[POS_W-1]}}, seg_t} + offs;
		if (tgt_w > TGT_MAX) begin
			tgt = POS_W'(TGT_MAX);
		end else if (tgt_w < TGT_MIN) begin
			tgt = POS_W'(TGT_MIN);
		end else begin
			tgt = POS_W'(tgt_w);
		end
		diff = {tgt[POS_W-1], tgt} - {pos_q[POS_W-1], pos_q};
		dmag = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
		tick_cnt = (|dmag[POS_W:CNT_W]) ? {CNT_W{1'b1}} : dmag[CNT_W-1:0];
	end

	// next state per opcode
	always_comb begin
		pos_n = pos_q;
		seg_n = seg_q;
		ms_n = ms_q;
		sneg_n = sneg_q;
		whole_n = whole_q;
		part_n = part_q;
		quo_n = quo_q;
		rem_n = rem_q;
		chg_n = chg_q;
		jog_n = jog_q;
		lim_n = lim_q;
		dir_n = dir_q;
		en_n = en_q;
		steps = '0;
		acc = 1'b0;
		retr = (SPD_W+1)'(cfg.retraction_steps) + (SPD_W+1)'(1);
		unique case (cmd.opcode)
			OP_TICK: begin
				if (jog_q) begin
					seg_n = seg_t;
					ms_n = ms_t;
					quo_n = quo_t;
					rem_n = rem_t;
					chg_n = 1'b0;
					if (diff != '0) begin
						dir_n = diff[POS_W];
						if (!lim_q) begin
							pos_n = tgt;
							steps = tick_cnt;
						end
					end
				end
			end
			OP_SET_SPEED: begin
				if (spd.ok) begin
					sneg_n = spd.neg;
					whole_n = spd.whole;
					part_n = spd.part;
					chg_n = 1'b1;
					acc = 1'b1;
				end
			end
			OP_START_JOG: begin
				jog_n = 1'b1;
				sneg_n = 1'b0;
				whole_n = '0;
				part_n = '0;
				chg_n = 1'b1;
				en_n = 1'b1;
			end
			OP_STOP_JOG: begin
				jog_n = 1'b0;
				if (!cfg.keep_powered) begin
					en_n = 1'b0;
				end
			end
			OP_LIMIT: begin
				lim_n = 1'b1;
				dir_n = ~dir_q;
				steps = CNT_W'(retr);
				pos_n = dir_n ? pos_q - POS_W'(retr) : pos_q + POS_W'(retr);
			end
			OP_CLR_LIMIT: begin
				lim_n = 1'b0;
			end
			OP_STEP: begin
				if (!lim_q) begin
					pos_n = dir_q ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
					steps = CNT_W'(1);
				end
			end
			OP_SET_POS: begin
				pos_n = POS_W'(cmd.value);
			end
			OP_SET_DIR: begin
				dir_n = (cmd.value != '0);
			end
			default: begin
			end
		endcase
	end

	// result reports the state after the command
	always_comb begin
		res.step_count = steps;
		res.direction_pin = dir_n ^ cfg.direction_flipped;
		res.position = pos_n;
		res.limit_active = lim_n;
		res.jog_active = jog_n;
		res.enable_pin = ~(en_n ^ cfg.enable_polarity);
		res.accepted = acc;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			seg_q <= '0;
			ms_q <= '0;
			sneg_q <= 1'b0;
			whole_q <= '0;
			part_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			chg_q <= 1'b0;
			jog_q <= 1'b0;
			lim_q <= 1'b0;
			dir_q <= 1'b0;
			en_q <= 1'b0;
		end else if (kp_wr.we) begin
			en_q <= kp_wr.val;
		end else if (adv) begin
			pos_q <= pos_n;
			seg_q <= seg_n;
			ms_q <= ms_n;
			sneg_q <= sneg_n;
			whole_q <= whole_n;
			part_q <= part_n;
			quo_q <= quo_n;
			rem_q <= rem_n;
			chg_q <= chg_n;
			jog_q <= jog_n;
			lim_q <= lim_n;
			dir_q <= dir_n;
			en_q <= en_n;
		end
	end

`ifndef NO_ASSERTIONS
	// partial-step remainder stays below one full step
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < R_W'(TICKS_PER_SECOND) || TICKS_PER_SECOND == 1)
		else $error("jog remainder out of range");

	// a tick never moves the motor while the limit flag is set
	a_tick_limit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !kp_wr.we && cmd.opcode == OP_TICK && lim_q |=> $stable(pos_q))
		else $error("tick moved position under limit");

	// a single step moves exactly one step in the current direction
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !kp_wr.we && cmd.opcode == OP_STEP && !lim_q |=>
		(pos_q - $past(pos_q)) == ($past(dir_q) ? {POS_W{1'b1}} : POS_W'(1)))
		else $error("single step moved wrong amount");
`endif

endmodule
